/* rtl/lmsl_pkg.sv */
// ----------------------------------------------------------------------------
// lmsl_pkg
// types and constants shared by the linear move speed limiter
// ----------------------------------------------------------------------------
`default_nettype none

package lmsl_pkg;

  localparam int DistW  = 24;
  localparam int SpeedW = 24;
  localparam int DvdW   = 55;
  localparam int DvsW   = 32;

  localparam logic [1:0] STATUS_SELECTED = 2'd0;
  localparam logic [1:0] STATUS_FALLBACK = 2'd1;
  localparam logic [1:0] STATUS_NO_MOVE  = 2'd2;

  localparam logic [1:0] CFG_SELECTED_GROUP = 2'd0;
  localparam logic [1:0] CFG_GROUP_SPEEDS   = 2'd1;
  localparam logic [1:0] CFG_GROUP_MASKS    = 2'd2;
  localparam logic [1:0] CFG_AXIS_MAX       = 2'd3;

  typedef struct packed {
    logic signed [DistW-1:0] dist_axis0;
    logic signed [DistW-1:0] dist_axis1;
    logic signed [DistW-1:0] dist_axis2;
    logic signed [DistW-1:0] dist_axis3;
    logic [DistW-1:0]        move_norm;
  } lmsl_in_t;

  typedef struct packed {
    logic [SpeedW-1:0] move_speed;
    logic [1:0]        used_group;
    logic [1:0]        status;
    logic              axis_limited;
  } lmsl_out_t;

endpackage

`default_nettype wire

/* rtl/lmsl_div.sv */
// ----------------------------------------------------------------------------
// lmsl_div
// restoring divider, one quotient bit per cycle, quotient saturated to 24 bits
// ----------------------------------------------------------------------------
`default_nettype none

module lmsl_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lmsl_pkg::DvdW-1:0]  dividend,
  input  wire logic [lmsl_pkg::DvsW-1:0]  divisor,
  output logic                            done,
  output logic [lmsl_pkg::SpeedW-1:0]     quotient
);
  import lmsl_pkg::*;

  logic [DvdW-1:0]   dvd_r;
  logic [DvsW-1:0]   dvs_r;
  logic [DvsW-1:0]   rem_r;
  logic [SpeedW-1:0] q_r;
  logic              ovf_r;
  logic [5:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DvsW:0]     shifted;
  logic              fits;

  assign shifted = {rem_r, dvd_r[DvdW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= 6'(DvdW - 1);
      end else if (run_r) begin
        dvd_r <= {dvd_r[DvdW-2:0], 1'b0};
        rem_r <= fits ? DvsW'(shifted - {1'b0, dvs_r}) : shifted[DvsW-1:0];
        q_r   <= {q_r[SpeedW-2:0], fits};
        ovf_r <= ovf_r | q_r[SpeedW-1];
        if (cnt_r == 6'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = ovf_r ? {SpeedW{1'b1}} : q_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !run_r) else $error("divider done while running");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while running");

endmodule

`default_nettype wire

/* rtl/linear_move_speed_limiter.sv */
// ----------------------------------------------------------------------------
// linear_move_speed_limiter
// group speed from the move norm and the root of the group's squared
// distances, then lowered so that no axis exceeds its maximum
// ----------------------------------------------------------------------------
// steps: square each axis, add the masked squares of each group searched,
//   take the root, divide, then divide again for each axis over its limit
// throughput: one move at a time, set by the shared restoring divider (55 steps)
// and the 32-step square root; busy stays high until the result strobe
// reset: synchronous active-low, state, strobe and settings cleared to zero
// results are strobed for one cycle and cannot be stalled
`default_nettype none

module linear_move_speed_limiter #(
  parameter int AXES   = 4,
  parameter int GROUPS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lmsl_pkg::lmsl_in_t  in_data,
  output logic                     out_valid,
  output lmsl_pkg::lmsl_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);
  import lmsl_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SUM  = 4'd2;
  localparam logic [3:0] ST_SQRT = 4'd3;
  localparam logic [3:0] ST_MULG = 4'd4;
  localparam logic [3:0] ST_DIVS = 4'd5;
  localparam logic [3:0] ST_DIVW = 4'd6;
  localparam logic [3:0] ST_AX   = 4'd7;
  localparam logic [3:0] ST_AXM1 = 4'd8;
  localparam logic [3:0] ST_AXM2 = 4'd9;
  localparam logic [3:0] ST_AXC  = 4'd10;
  localparam logic [3:0] ST_AXD  = 4'd11;

  localparam logic [1:0] LastAx = 2'(AXES - 1);
  localparam logic [1:0] LastGr = 2'(GROUPS - 1);

  logic [1:0]  sel_r;
  logic [63:0] gspeed_r;
  logic [15:0] gmask_r;
  logic [63:0] axmax_r;

  logic [3:0]        state_r;
  logic [DistW-1:0]  mag_r [4];
  logic [DistW-1:0]  norm_r;
  logic [47:0]       sq_r [4];
  logic [1:0]        ac_r;
  logic [1:0]        grp_r;
  logic              first_r;
  logic [48:0]       acc_r;
  logic [63:0]       rem_r;
  logic [63:0]       res_r;
  logic [63:0]       bit_r;
  logic [47:0]       prod_r;
  logic [47:0]       bound_r;
  logic [SpeedW-1:0] speed_r;
  logic [1:0]        used_r;
  logic [1:0]        status_r;
  logic              lim_r;
  logic              out_valid_r;
  lmsl_out_t         out_r;

  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] prod;
  logic [15:0] gs;
  logic [15:0] amax;
  logic        grp_ok;
  logic [48:0] term;
  logic [48:0] acc_sum;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic        div_start;
  logic [DvdW-1:0] div_dvd;
  logic [DvsW-1:0] div_dvs;
  logic        div_done;
  logic [SpeedW-1:0] div_q;

  function automatic logic [DistW-1:0] mag_of(input logic signed [DistW-1:0] d);
    return d[DistW-1] ? DistW'(~d + 1'b1) : d;
  endfunction

  assign gs     = gspeed_r[{used_r, 4'd0} +: 16];
  assign amax   = axmax_r[{ac_r, 4'd0} +: 16];
  assign grp_ok = {1'b0, grp_r} < 3'(GROUPS);
  assign term   = (grp_ok && gmask_r[{grp_r, ac_r}]) ? {1'b0, sq_r[ac_r]} : '0;
  assign acc_sum = acc_r + term;
  assign sq_t   = res_r + bit_r;
  assign sq_ge  = rem_r >= sq_t;

  always_comb begin
    mul_a = speed_r;
    mul_b = mag_r[ac_r];
    case (state_r)
      ST_SQ:   begin
        mul_a = mag_r[ac_r];
      end
      ST_MULG: begin
        mul_a = {8'd0, gs};
        mul_b = norm_r;
      end
      ST_AXM2: begin
        mul_a = {8'd0, amax};
        mul_b = norm_r;
      end
      default: begin
        mul_a = speed_r;
        mul_b = mag_r[ac_r];
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {prod_r[39:0], 15'd0};
    div_dvs   = res_r[DvsW-1:0];
    if (state_r == ST_DIVS) begin
      div_start = 1'b1;
    end else if (state_r == ST_AXC) begin
      div_start = prod_r > bound_r;
      div_dvd   = {7'd0, bound_r};
      div_dvs   = {8'd0, mag_r[ac_r]};
    end
  end

  lmsl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= '0;
      gspeed_r <= '0;
      gmask_r  <= '0;
      axmax_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECTED_GROUP: sel_r    <= cfg_wdata[1:0];
        CFG_GROUP_SPEEDS:   gspeed_r <= cfg_wdata;
        CFG_GROUP_MASKS:    gmask_r  <= cfg_wdata[15:0];
        CFG_AXIS_MAX:       axmax_r  <= cfg_wdata;
        default:            sel_r    <= sel_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            mag_r[0] <= mag_of(in_data.dist_axis0);
            mag_r[1] <= mag_of(in_data.dist_axis1);
            mag_r[2] <= mag_of(in_data.dist_axis2);
            mag_r[3] <= mag_of(in_data.dist_axis3);
            norm_r   <= in_data.move_norm;
            ac_r     <= '0;
            state_r  <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_r[ac_r] <= prod;
          if (ac_r == LastAx) begin
            ac_r    <= '0;
            grp_r   <= sel_r;
            first_r <= 1'b1;
            acc_r   <= '0;
            state_r <= ST_SUM;
          end else begin
            ac_r <= ac_r + 2'd1;
          end
        end
        ST_SUM: begin
          if (ac_r == LastAx) begin
            ac_r  <= '0;
            acc_r <= '0;
            if (acc_sum != '0) begin
              used_r   <= grp_r;
              status_r <= first_r ? STATUS_SELECTED : STATUS_FALLBACK;
              rem_r    <= {1'b0, acc_sum, 14'd0};
              res_r    <= '0;
              bit_r    <= 64'd1 << 62;
              state_r  <= ST_SQRT;
            end else if (!first_r && grp_r == LastGr) begin
              out_r       <= '{move_speed: '0, used_group: sel_r,
                               status: STATUS_NO_MOVE, axis_limited: 1'b0};
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              grp_r   <= first_r ? 2'd0 : grp_r + 2'd1;
              first_r <= 1'b0;
            end
          end else begin
            acc_r <= acc_sum;
            ac_r  <= ac_r + 2'd1;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            rem_r <= rem_r - sq_t;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_MULG;
          end
        end
        ST_MULG: begin
          prod_r  <= prod;
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            speed_r <= div_q;
            lim_r   <= 1'b0;
            ac_r    <= '0;
            state_r <= ST_AX;
          end
        end
        ST_AX: begin
          if (amax != '0 && mag_r[ac_r] != '0) begin
            state_r <= ST_AXM1;
          end else if (ac_r == LastAx) begin
            out_r       <= '{move_speed: speed_r, used_group: used_r,
                             status: status_r, axis_limited: lim_r};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            ac_r <= ac_r + 2'd1;
          end
        end
        ST_AXM1: begin
          prod_r  <= prod;
          state_r <= ST_AXM2;
        end
        ST_AXM2: begin
          bound_r <= {prod[39:0], 8'd0};
          state_r <= ST_AXC;
        end
        ST_AXC: begin
          if (div_start) begin
            state_r <= ST_AXD;
          end else if (ac_r == LastAx) begin
            out_r       <= '{move_speed: speed_r, used_group: used_r,
                             status: status_r, axis_limited: lim_r};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            ac_r    <= ac_r + 2'd1;
            state_r <= ST_AX;
          end
        end
        ST_AXD: begin
          if (div_done) begin
            speed_r <= div_q;
            lim_r   <= 1'b1;
            if (ac_r == LastAx) begin
              out_r       <= '{move_speed: div_q, used_group: used_r,
                               status: status_r, axis_limited: 1'b1};
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              ac_r    <= ac_r + 2'd1;
              state_r <= ST_AX;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transfer did not start work");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy)) else $error("result strobe outside work");
  a_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_NO_MOVE |->
      out_data.move_speed == '0 && !out_data.axis_limited)
    else $error("non-moving result carries a speed");
  a_div_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW || state_r == ST_AXD)
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

/* tb/lmsl_checker.sv */
// ----------------------------------------------------------------------------
// lmsl_checker
// tracks register writes, predicts the speed result of every accepted move
// and compares each strobed result, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module lmsl_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  lmsl_pkg::lmsl_in_t  in_data,
  input  logic                out_valid,
  input  lmsl_pkg::lmsl_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lmsl_pkg::*;

  logic [1:0]  sel_group;
  logic [63:0] group_speeds;
  logic [15:0] group_masks;
  logic [63:0] axis_max;
  lmsl_out_t   speed_q[$];

  assign pending = speed_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_dist(logic [23:0] v);
    return v[23] ? 64'h1000000 - {40'd0, v} : {40'd0, v};
  endfunction

  function automatic logic [63:0] sq_sum(int g, logic [63:0] mag[4]);
    logic [63:0] s;
    logic [3:0]  m;
    s = 0;
    m = group_masks[4*g +: 4];
    for (int a = 0; a < 4; a++) if (m[a]) s = s + mag[a] * mag[a];
    return s;
  endfunction

  function automatic lmsl_out_t predict_speed(lmsl_in_t mv);
    lmsl_out_t   r;
    logic [63:0] mag[4];
    logic [63:0] norm;
    logic [63:0] s;
    logic [63:0] spd;
    logic [63:0] gs;
    logic [63:0] lim;
    logic [63:0] bound;
    mag[0] = abs_dist(mv.dist_axis0);
    mag[1] = abs_dist(mv.dist_axis1);
    mag[2] = abs_dist(mv.dist_axis2);
    mag[3] = abs_dist(mv.dist_axis3);
    norm = {40'd0, mv.move_norm};
    r.used_group = sel_group;
    r.status = STATUS_SELECTED;
    r.axis_limited = 1'b0;
    spd = 0;
    s = sq_sum(sel_group, mag);
    if (s == 0) begin
      for (int g = 0; g < 4; g++) begin
        if (g != sel_group && s == 0) begin
          s = sq_sum(g, mag);
          if (s != 0) begin
            r.used_group = g[1:0];
            r.status = STATUS_FALLBACK;
          end
        end
      end
    end
    if (s == 0) begin
      r.status = STATUS_NO_MOVE;
      r.used_group = sel_group;
    end else begin
      gs = {48'd0, group_speeds[16*r.used_group +: 16]};
      spd = ((gs * norm) << 15) / int_sqrt(s << 14);
      if (spd > 64'hFFFFFF) spd = 64'hFFFFFF;
      for (int a = 0; a < 4; a++) begin
        lim = {48'd0, axis_max[16*a +: 16]};
        bound = lim * 256 * norm;
        if (lim != 0 && mag[a] != 0 && spd * mag[a] > bound) begin
          spd = bound / mag[a];
          r.axis_limited = 1'b1;
        end
      end
    end
    r.move_speed = spd[23:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    lmsl_out_t w;
    if (!rst_n) begin
      sel_group <= '0;
      group_speeds <= '0;
      group_masks <= '0;
      axis_max <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SELECTED_GROUP: sel_group <= cfg_wdata[1:0];
          CFG_GROUP_SPEEDS:   group_speeds <= cfg_wdata;
          CFG_GROUP_MASKS:    group_masks <= cfg_wdata[15:0];
          CFG_AXIS_MAX:       axis_max <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (speed_q.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          w = speed_q.pop_front();
          if (out_data.move_speed !== w.move_speed)
            report("move_speed", out_data.move_speed, w.move_speed);
          if (out_data.used_group !== w.used_group)
            report("used_group", out_data.used_group, w.used_group);
          if (out_data.status !== w.status)
            report("status", out_data.status, w.status);
          if (out_data.axis_limited !== w.axis_limited)
            report("axis_limited", out_data.axis_limited, w.axis_limited);
        end
      end
      if (start && !busy) speed_q.push_back(predict_speed(in_data));
    end
  end
endmodule

/* tb/linear_move_speed_limiter_tb.sv */
// ----------------------------------------------------------------------------
// linear_move_speed_limiter_tb
// drives directed and random moves through several register settings with
// random gaps on the start side; the checker predicts and compares results
// ----------------------------------------------------------------------------
module linear_move_speed_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmsl_pkg::*;

  localparam int WatchLimit = 6000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  lmsl_in_t    in_data = '0;
  logic        out_valid;
  lmsl_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SELECTED_GROUP;
  logic [63:0] cfg_wdata = '0;
  int          errors;
  int          pending;
  int          quiet = 0;
  int          idle_pct = 0;

  always #4 clk = ~clk;

  linear_move_speed_limiter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lmsl_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .errors(errors),
    .pending(pending)
  );

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_regs(logic [1:0] sel, logic [63:0] gs, logic [15:0] masks,
                          logic [63:0] amax);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SELECTED_GROUP;
    cfg_wdata <= {62'd0, sel};
    @(posedge clk);
    cfg_index <= CFG_GROUP_SPEEDS;
    cfg_wdata <= gs;
    @(posedge clk);
    cfg_index <= CFG_GROUP_MASKS;
    cfg_wdata <= {48'd0, masks};
    @(posedge clk);
    cfg_index <= CFG_AXIS_MAX;
    cfg_wdata <= amax;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_move(lmsl_in_t mv);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= mv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_dist();
    logic [23:0] d;
    int w;
    if ($urandom_range(9) < 3) return 24'd0;
    if ($urandom_range(29) == 0) return 24'h800000;
    w = $urandom_range(1, 23);
    d = 24'($urandom_range(0, (1 << w) - 1));
    return $urandom_range(1) ? -d : d;
  endfunction

  function automatic lmsl_in_t rand_move();
    lmsl_in_t mv;
    real      s;
    mv.dist_axis0 = rand_dist();
    mv.dist_axis1 = rand_dist();
    mv.dist_axis2 = rand_dist();
    mv.dist_axis3 = rand_dist();
    s = real'(mv.dist_axis0) ** 2 + real'(mv.dist_axis1) ** 2 +
        real'(mv.dist_axis2) ** 2 + real'(mv.dist_axis3) ** 2;
    s = $sqrt(s);
    mv.move_norm = (s > 16777215.0) ? 24'hFFFFFF : 24'($rtoi(s));
    if ($urandom_range(4) == 0) mv.move_norm = 24'($urandom());
    return mv;
  endfunction

  function automatic logic [15:0] rand_masks();
    logic [15:0] m;
    m = 16'($urandom());
    for (int g = 0; g < 4; g++) if ($urandom_range(2) == 0) m[4*g +: 4] = 4'd0;
    return m;
  endfunction

  function automatic logic [63:0] rand_limits();
    logic [63:0] v;
    v = rand64();
    for (int a = 0; a < 4; a++) begin
      case ($urandom_range(3))
        0: v[16*a +: 16] = 16'd0;
        1: v[16*a +: 16] = 16'($urandom_range(1, 300));
        default: ;
      endcase
    end
    return v;
  endfunction

  initial begin
    lmsl_in_t mv;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one axis per group, mixed limits
    set_regs(2'd0, 64'hFFFF_0001_1234_0064, 16'h8421, 64'h0000_FFFF_0001_0050);
    mv = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'd0};
    send_move(mv);
    mv = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF};
    send_move(mv);
    mv = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'hFFFFFF};
    send_move(mv);
    mv = '{24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'd0};
    send_move(mv);
    mv = '{24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'hFFFFFF};
    send_move(mv);
    mv = '{24'sd0, -24'sd512, 24'sd0, 24'sd0, 24'd512};
    send_move(mv);
    mv = '{24'sd0, 24'sd0, 24'sd768, 24'sd0, 24'd768};
    send_move(mv);
    mv = '{24'sd0, 24'sd0, 24'sd0, -24'sd1024, 24'd1024};
    send_move(mv);
    mv = '{24'sd768, 24'sd1024, 24'sd0, 24'sd0, 24'd1280};
    send_move(mv);
    mv = '{24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'd2};
    send_move(mv);
    drain();
    set_regs(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 64'h0);
    send_move(mv);
    mv = '{24'sh7FFFFF, 24'sd0, 24'sd0, 24'sd0, 24'hFFFFFF};
    send_move(mv);
    drain();
    set_regs(2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 16'h00F0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_move(mv);
    mv = '{24'sd0, 24'sd0, 24'sd5, 24'sd0, 24'd5};
    send_move(mv);
    drain();

    for (int p = 0; p < 9; p++) begin
      idle_pct = (p < 3) ? 35 : (p < 6) ? 57 : 0;
      case (p)
        0: set_regs(2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        4: set_regs(2'd3, 64'h0001_0001_0001_0001, 16'hF000, 64'h0001_0001_0001_0001);
        default: set_regs(2'($urandom()), rand64(), rand_masks(), rand_limits());
      endcase
      repeat (120) send_move(rand_move());
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/lmsl_pkg.sv
rtl/lmsl_div.sv
rtl/linear_move_speed_limiter.sv
tb/lmsl_checker.sv
tb/linear_move_speed_limiter_tb.sv
